// ----- src/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg
// Types, constants and helper functions shared by the rectangular/polar
// converter and its channel interfaces.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int GUARD         = 16;          // extra fraction bits in x/y
  localparam int CW            = 32;          // coordinate width, Q16.16
  localparam int XW            = 52;          // x/y datapath width
  localparam int ZW            = 44;          // angle accumulator, Q12.32 deg
  localparam int DW            = XW - GUARD;  // x/y after guard bits dropped
  localparam int AW            = ZW - 16;     // angle after rounding to Q16

  localparam logic [31:0] INV_GAIN        = 32'h9B74EDA8;
  localparam logic [63:0] DEG_PER_RAD_Q26 = 64'd3845054675;

  // 360 deg in Q16.16 is 45 << 19; the turn count mod 45 goes through a
  // reciprocal multiply on a biased 14-bit value.
  localparam int          TURN_SHIFT       = 19;
  localparam int          TURN_DIV         = 45;
  localparam logic [13:0] WRAP_BIAS        = 14'd4140;   // 92 * 45
  localparam logic [13:0] WRAP_RECIP       = 14'd11651;  // ceil(2^19 / 45)
  localparam int          WRAP_RECIP_SHIFT = 19;

  localparam logic signed [25:0] DEG90_Q16  = 26'sd5898240;
  localparam logic signed [25:0] DEG180_Q16 = 26'sd11796480;
  localparam logic signed [25:0] DEG360_Q16 = 26'sd23592960;
  localparam logic signed [ZW-1:0] DEG180_Q32 = ZW'(64'd180 << 32);

  typedef logic signed [XW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;

  typedef enum logic {
    REQ_RECT_TO_POLAR = 1'b0,
    REQ_POLAR_TO_RECT = 1'b1
  } req_type_t;

  typedef struct packed {
    logic                 sat;
    logic signed [CW-1:0] value;
  } sat_t;

  // Shift-subtract divide, only evaluated while building constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in degrees, Q.32: Taylor series in Q60 radians, cut to Q32,
  // scaled by 180/pi in Q26.
  function automatic logic [63:0] atan_deg_q32(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned p;
    int unsigned k;
    sum = '0;
    if (i == 0) return 64'd45 << 32;
    for (k = 0; k < 61; k++) begin
      p = i * (2 * k + 1);
      if (p <= 60) begin
        term = udiv64(64'd1 << (60 - p), 64'(2 * k + 1));
        if (k[0]) sum = sum - term;
        else      sum = sum + term;
      end
    end
    return ((sum >> 28) * DEG_PER_RAD_Q26) >> 26;
  endfunction

  // Round half up while dropping the guard bits.
  function automatic logic signed [DW-1:0] drop_guard(input vec_t v);
    vec_t t;
    t = v + (vec_t'(1) <<< (GUARD - 1));
    return t[XW-1:GUARD];
  endfunction

  function automatic sat_t sat32(input logic signed [DW-1:0] v);
    sat_t r;
    if (v[DW-1:CW-1] != {(DW-CW+1){v[DW-1]}}) begin
      r.sat   = 1'b1;
      r.value = v[DW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      r.sat   = 1'b0;
      r.value = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/rpc_req_if.sv -----
// ----------------------------------------------------------------------------
// rpc_req_if
// Request channel: conversion type and two Q16.16 coordinates.
// ----------------------------------------------------------------------------
interface rpc_req_if import rpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  req_type_t            req_type;
  logic signed [CW-1:0] first_coord;
  logic signed [CW-1:0] second_coord;

  modport source (output valid, req_type, first_coord, second_coord, input ready);
  modport sink   (input valid, req_type, first_coord, second_coord, output ready);
endinterface

// ----- src/rpc_res_if.sv -----
// ----------------------------------------------------------------------------
// rpc_res_if
// Result channel: two Q16.16 results and the saturation flag.
// ----------------------------------------------------------------------------
interface rpc_res_if import rpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] first_result;
  logic signed [CW-1:0] second_result;
  logic                 saturated;

  modport source (output valid, first_result, second_result, saturated, input ready);
  modport sink   (input valid, first_result, second_result, saturated, output ready);
endinterface

// ----- src/rect_polar_converter.sv -----
// ----------------------------------------------------------------------------
// rect_polar_converter
// CORDIC rectangular <-> polar converter, fully pipelined.
// ----------------------------------------------------------------------------
// One request goes in per cycle while ready is high; each gives one result
// after passing the input register, three
// stages of setup (vectoring fold or angle wrap and gain scaling), one
// register per unrolled CORDIC iteration, three stages of gain correction,
// rounding and saturation, then the output register. Throughput is one
// request per cycle while the skid is empty, set by the unrolled iteration
// stages. A one-entry skid behind the output register lets the pipe keep taking
// requests after the result side stops; ready drops only while the skid entry is full.
module rect_polar_converter import rpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  rpc_req_if.sink  req,
  rpc_res_if.source res
);

  localparam int NS   = CORDIC_STAGES + 7;
  localparam int LAST = NS - 1;

  logic          en;
  logic [NS-1:0] vld;

  // output register and skid entry
  logic                 out_v, skid_v;
  logic signed [CW-1:0] out_first, out_second, skid_first, skid_second;
  logic                 out_sat, skid_sat;

  assign en        = !skid_v;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], req.valid};
    end
  end

  // ---------------------------------------------------------------- stage A
  req_type_t            a_mode;
  logic signed [CW-1:0] a_x, a_y;

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode <= req.req_type;
      a_x    <= req.first_coord;
      a_y    <= req.second_coord;
    end
  end

  // ---------------------------------------------------------------- stage B
  logic [12:0]     q13;
  logic [13:0]     qoff_next;
  logic [27:0]     qm_next;
  logic            aneg_next;
  logic [CW-1:0]   abs_a;
  logic [63:0]     prod_next;
  vec_t            xs, ys, bx_next, by_next;
  ang_t            bz_next;
  logic            zero_next;

  always_comb begin
    q13       = a_y[CW-1:TURN_SHIFT];
    qoff_next = {q13[12], q13} + WRAP_BIAS;
    qm_next   = 28'(qoff_next) * 28'(WRAP_RECIP);
    aneg_next = a_x[CW-1];
    abs_a     = aneg_next ? CW'(-a_x) : CW'(a_x);
    prod_next = 64'(abs_a) * 64'(INV_GAIN);

    // left half plane: fold onto the right and start the angle at +-180
    xs        = vec_t'(a_x) <<< GUARD;
    ys        = vec_t'(a_y) <<< GUARD;
    zero_next = (a_x == '0) && (a_y == '0);
    if (aneg_next) begin
      bx_next = -xs;
      by_next = -ys;
      bz_next = a_y[CW-1] ? -DEG180_Q32 : DEG180_Q32;
    end else begin
      bx_next = xs;
      by_next = ys;
      bz_next = '0;
    end
  end

  req_type_t             b_mode;
  logic [13:0]           b_qoff;
  logic [27:0]           b_qm;
  logic [TURN_SHIFT-1:0] b_low;
  logic                  b_aneg;
  logic [63:0]           b_prod;
  vec_t                  b_x, b_y;
  ang_t                  b_z;
  logic                  b_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      b_mode <= a_mode;
      b_qoff <= qoff_next;
      b_qm   <= qm_next;
      b_low  <= a_y[TURN_SHIFT-1:0];
      b_aneg <= aneg_next;
      b_prod <= prod_next;
      b_x    <= bx_next;
      b_y    <= by_next;
      b_z    <= bz_next;
      b_zero <= zero_next;
    end
  end

  // ---------------------------------------------------------------- stage C
  logic [8:0]  quot;
  logic [13:0] rem;
  logic [63:0] gsum;

  always_comb begin
    quot = b_qm[27:WRAP_RECIP_SHIFT];
    rem  = b_qoff - 14'(quot) * 14'(TURN_DIV);
    gsum = b_prod + 64'h8000;
  end

  req_type_t               c_mode;
  logic [TURN_SHIFT+5:0]   c_r;     // angle mod 360, [0, 360) deg
  logic [47:0]             c_gmag;
  logic                    c_aneg;
  vec_t                    c_x, c_y;
  ang_t                    c_z;
  logic                    c_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      c_mode <= b_mode;
      c_r    <= {rem[5:0], b_low};
      c_gmag <= gsum[63:16];
      c_aneg <= b_aneg;
      c_x    <= b_x;
      c_y    <= b_y;
      c_z    <= b_z;
      c_zero <= b_zero;
    end
  end

  // ---------------------------------------------------------------- stage D
  logic signed [25:0] r_wrap, r_fold;
  logic               flip;
  vec_t               gm, dx_next, dy_next;
  ang_t               dz_next;

  always_comb begin
    r_wrap = $signed({1'b0, c_r});
    if (r_wrap > DEG180_Q16) r_wrap = r_wrap - DEG360_Q16;
    // beyond +-90 deg: rotate by 180 and start from the negated vector
    flip   = 1'b0;
    r_fold = r_wrap;
    if (r_wrap > DEG90_Q16) begin
      r_fold = r_wrap - DEG180_Q16;
      flip   = 1'b1;
    end else if (r_wrap < -DEG90_Q16) begin
      r_fold = r_wrap + DEG180_Q16;
      flip   = 1'b1;
    end
    gm = vec_t'(c_gmag);
    if (c_mode == REQ_POLAR_TO_RECT) begin
      dx_next = (c_aneg ^ flip) ? -gm : gm;
      dy_next = '0;
      dz_next = ZW'(r_fold) <<< 16;
    end else begin
      dx_next = c_x;
      dy_next = c_y;
      dz_next = c_z;
    end
  end

  vec_t      cx    [CORDIC_STAGES+1];
  vec_t      cy    [CORDIC_STAGES+1];
  ang_t      cz    [CORDIC_STAGES+1];
  req_type_t cm    [CORDIC_STAGES+1];
  logic      czero [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]    <= dx_next;
      cy[0]    <= dy_next;
      cz[0]    <= dz_next;
      cm[0]    <= c_mode;
      czero[0] <= c_zero;
    end
  end

  // ------------------------------------------------------- CORDIC iterations
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    localparam ang_t AT = ZW'(atan_deg_q32(i));
    logic plus;
    vec_t nx, ny;
    ang_t nz;

    always_comb begin
      // vectoring drives y to zero, rotation drives z to zero
      plus = (cm[i] == REQ_POLAR_TO_RECT) ? cz[i][ZW-1] : !cy[i][XW-1];
      if (plus) begin
        nx = cx[i] + (cy[i] >>> i);
        ny = cy[i] - (cx[i] >>> i);
        nz = cz[i] + AT;
      end else begin
        nx = cx[i] - (cy[i] >>> i);
        ny = cy[i] + (cx[i] >>> i);
        nz = cz[i] - AT;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx[i+1]    <= nx;
        cy[i+1]    <= ny;
        cz[i+1]    <= nz;
        cm[i+1]    <= cm[i];
        czero[i+1] <= czero[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage E
  vec_t               xf, yf;
  ang_t               zf, zrnd;
  logic [XW-1:0]      ux;
  logic signed [AW-1:0] zq;
  logic signed [CW-1:0] ang_next;

  always_comb begin
    xf   = cx[CORDIC_STAGES];
    yf   = cy[CORDIC_STAGES];
    zf   = cz[CORDIC_STAGES];
    ux   = xf[XW-1] ? XW'(-xf) : XW'(xf);
    zrnd = zf + ang_t'(1 <<< 15);
    zq   = zrnd[ZW-1:16];
    if (zq > DEG180_Q16)       ang_next = CW'(DEG180_Q16);
    else if (zq < -DEG180_Q16) ang_next = -CW'(DEG180_Q16);
    else                       ang_next = CW'(zq);
  end

  req_type_t            e_mode;
  logic                 e_zero, e_xneg;
  logic [63:0]          e_lo;
  logic [XW-33:0]       e_uhi;
  logic signed [CW-1:0] e_ang;
  logic signed [DW-1:0] e_dx, e_dy;

  always_ff @(posedge clk) begin
    if (en) begin
      e_mode <= cm[CORDIC_STAGES];
      e_zero <= czero[CORDIC_STAGES];
      e_xneg <= xf[XW-1];
      e_lo   <= 64'(ux[31:0]) * 64'(INV_GAIN);
      e_uhi  <= ux[XW-1:32];
      e_ang  <= ang_next;
      e_dx   <= drop_guard(xf);
      e_dy   <= drop_guard(yf);
    end
  end

  // ---------------------------------------------------------------- stage F
  sat_t sx, sy;

  always_comb begin
    sx = sat32(e_dx);
    sy = sat32(e_dy);
  end

  req_type_t            f_mode;
  logic                 f_zero, f_xneg;
  logic [XW-1:0]        f_gmag;
  logic signed [CW-1:0] f_ang, f_first, f_second;
  logic                 f_sat;

  always_ff @(posedge clk) begin
    if (en) begin
      f_mode   <= e_mode;
      f_zero   <= e_zero;
      f_xneg   <= e_xneg;
      f_gmag   <= XW'(64'(e_uhi) * 64'(INV_GAIN)) + XW'((e_lo + 64'h8000_0000) >> 32);
      f_ang    <= e_ang;
      f_first  <= sx.value;
      f_second <= sy.value;
      f_sat    <= sx.sat | sy.sat;
    end
  end

  // ---------------------------------------------------------------- stage G
  vec_t                 gx;
  sat_t                 smag;
  logic signed [CW-1:0] gfirst_next, gsecond_next;
  logic                 gsat_next;

  always_comb begin
    gx   = f_xneg ? -vec_t'(f_gmag) : vec_t'(f_gmag);
    smag = sat32(drop_guard(gx));
    if (f_mode == REQ_POLAR_TO_RECT) begin
      gfirst_next  = f_first;
      gsecond_next = f_second;
      gsat_next    = f_sat;
    end else if (f_zero) begin
      gfirst_next  = '0;
      gsecond_next = '0;
      gsat_next    = 1'b0;
    end else begin
      gfirst_next  = smag.value;
      gsecond_next = f_ang;
      gsat_next    = smag.sat;
    end
  end

  logic signed [CW-1:0] g_first, g_second;
  logic                 g_sat;

  always_ff @(posedge clk) begin
    if (en) begin
      g_first  <= gfirst_next;
      g_second <= gsecond_next;
      g_sat    <= gsat_next;
    end
  end

  // ------------------------------------------------ output register and skid
  logic pop, push;

  assign pop  = out_v && res.ready;
  assign push = en && vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pop) begin
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (out_v && !pop) begin
        skid_v <= 1'b1;
      end else begin
        out_v <= 1'b1;
      end
    end else if (pop) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (pop) begin
        out_first  <= skid_first;
        out_second <= skid_second;
        out_sat    <= skid_sat;
      end
    end else if (push) begin
      if (out_v && !pop) begin
        skid_first  <= g_first;
        skid_second <= g_second;
        skid_sat    <= g_sat;
      end else begin
        out_first  <= g_first;
        out_second <= g_second;
        out_sat    <= g_sat;
      end
    end
  end

  assign res.valid         = out_v;
  assign res.first_result  = out_first;
  assign res.second_result = out_second;
  assign res.saturated     = out_sat;

endmodule

// ----- sim/rpc_conv_checker.sv -----
// ----------------------------------------------------------------------------
// rpc_conv_checker
// Watches the request and result channels of the rectangular/polar converter.
// Every accepted request is run through a bit-exact CORDIC predictor; each
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rpc_conv_checker import rpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rpc_req_if          req,
  rpc_res_if          res,
  output int unsigned mismatch_count,
  output int unsigned results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          N_STAGES    = CORDIC_STAGES;
  localparam int          FRAC_GUARD  = 16;
  localparam logic [63:0] GAIN_RECIP  = 64'h0000_0000_9B74_EDA8;
  localparam logic [63:0] RAD2DEG_Q26 = 64'd3845054675;
  localparam longint      I32_MAX     = 64'sd2147483647;
  localparam longint      I32_MIN     = -64'sd2147483648;
  localparam longint      Q16_DEG90   = 64'sd5898240;
  localparam longint      Q16_DEG180  = 64'sd11796480;
  localparam longint      Q16_DEG360  = 64'sd23592960;
  localparam longint      Q32_DEG180  = 64'sd773094113280;

  typedef struct packed {
    logic signed [31:0] first_result;
    logic signed [31:0] second_result;
    logic               saturated;
  } conv_result_t;

  longint       atan_deg [N_STAGES];
  conv_result_t pending_results [$];
  int unsigned  fail_tally;

  // atan(2^-i) in degrees, Q.32, from the odd power series in Q60 radians
  function automatic longint atan_entry(input int unsigned i);
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned p;
    acc = '0;
    if (i == 0) return longint'(64'd45 << 32);
    for (int unsigned k = 0; k < 61; k++) begin
      p = i * (2 * k + 1);
      if (p <= 60) begin
        term = (64'd1 << (60 - p)) / 64'(2 * k + 1);
        if (k % 2 == 1) acc = acc - term;
        else            acc = acc + term;
      end
    end
    return longint'(((acc >> 28) * RAD2DEG_Q26) >> 26);
  endfunction

  // multiply by 1/K, rounding half away from zero
  function automatic longint gain_correct(input longint v);
    logic [63:0] mag;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] prod;
    mag  = (v < 0) ? 64'(-v) : 64'(v);
    hi   = (mag >> 32) * GAIN_RECIP;
    lo   = {32'd0, mag[31:0]} * GAIN_RECIP;
    prod = hi + ((lo + 64'h8000_0000) >> 32);
    return (v < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic longint round_off_guard(input longint v);
    return (v + 64'sd32768) >>> FRAC_GUARD;
  endfunction

  function automatic logic signed [31:0] clamp_i32(input longint v, inout logic hit);
    if (v > I32_MAX) begin
      hit = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < I32_MIN) begin
      hit = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic conv_result_t convert_vector(input req_type_t kind,
                                                  input logic signed [31:0] c1,
                                                  input logic signed [31:0] c2);
    conv_result_t r;
    longint       a;
    longint       b;
    longint       x;
    longint       y;
    longint       z;
    longint       nx;
    longint       ny;
    longint       wrapped;
    logic         flip;
    logic         hit;
    a    = longint'(c1);
    b    = longint'(c2);
    hit  = 1'b0;
    flip = 1'b0;
    if (kind == REQ_RECT_TO_POLAR) begin
      if (a == 0 && b == 0) begin
        r = '0;
        return r;
      end
      x = a * 65536;
      y = b * 65536;
      z = 0;
      // left half plane: fold over and start from +/-180
      if (x < 0) begin
        z = (b >= 0) ? Q32_DEG180 : -Q32_DEG180;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < N_STAGES; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z  = z + atan_deg[i];
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z  = z - atan_deg[i];
        end
        x = nx;
        y = ny;
      end
      x = round_off_guard(gain_correct(x));
      z = (z + 64'sd32768) >>> 16;
      if (z > Q16_DEG180)  z = Q16_DEG180;
      if (z < -Q16_DEG180) z = -Q16_DEG180;
      r.first_result  = clamp_i32(x, hit);
      r.second_result = z[31:0];
    end else begin
      // reduce to (-180, 180], then fold into [-90, 90]
      wrapped = b % Q16_DEG360;
      if (wrapped < 0)          wrapped = wrapped + Q16_DEG360;
      if (wrapped > Q16_DEG180) wrapped = wrapped - Q16_DEG360;
      if (wrapped > Q16_DEG90) begin
        wrapped = wrapped - Q16_DEG180;
        flip    = 1'b1;
      end else if (wrapped < -Q16_DEG90) begin
        wrapped = wrapped + Q16_DEG180;
        flip    = 1'b1;
      end
      x = gain_correct(a * 65536);
      if (flip) x = -x;
      y = 0;
      z = wrapped * 65536;
      for (int i = 0; i < N_STAGES; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z  = z - atan_deg[i];
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z  = z + atan_deg[i];
        end
        x = nx;
        y = ny;
      end
      r.first_result  = clamp_i32(round_off_guard(x), hit);
      r.second_result = clamp_i32(round_off_guard(y), hit);
    end
    r.saturated = hit;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < N_STAGES; i++) atan_deg[i] = atan_entry(i);
  end

  always @(posedge clk) begin
    conv_result_t want;
    if (rst) begin
      pending_results.delete();
      fail_tally = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_tally++;
        end else begin
          want = pending_results.pop_front();
          if (res.first_result !== want.first_result) begin
            $error("first_result: expected %0d, got %0d", want.first_result, res.first_result);
            fail_tally++;
          end
          if (res.second_result !== want.second_result) begin
            $error("second_result: expected %0d, got %0d",
                   want.second_result, res.second_result);
            fail_tally++;
          end
          if (res.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, res.saturated);
            fail_tally++;
          end
        end
      end
      if (req.valid && req.ready)
        pending_results.push_back(convert_vector(req.req_type, req.first_coord,
                                                 req.second_coord));
    end
    mismatch_count <= fail_tally;
    results_owed   <= pending_results.size();
  end

endmodule

// ----- sim/tb_rect_polar_converter.sv -----
// ----------------------------------------------------------------------------
// tb_rect_polar_converter
// Drives directed and random conversion requests into the CORDIC converter
// with random request gaps and result-side stalls; the checker predicts and
// compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_rect_polar_converter;
  timeunit 1ns;
  timeprecision 1ps;
  import rpc_pkg::*;

  localparam int PHASE_ITEMS = 600;
  localparam int DRAIN_TAIL  = 40;

  logic        clk;
  logic        rst;
  int          send_idle_pct = 22;
  int          recv_idle_pct = 65;
  int unsigned mismatch_count;
  int unsigned results_owed;

  rpc_req_if req_ch ();
  rpc_res_if res_ch ();

  rect_polar_converter dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  rpc_conv_checker chk (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .res            (res_ch),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic issue_conversion(input req_type_t kind, input logic [31:0] c1,
                                  input logic [31:0] c2);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.first_coord  <= c1;
    req_ch.second_coord <= c2;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // hold requests off until the pipe has handed back everything
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_coord(input logic angle_field);
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1, 2: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1) == 1) v = -v;
      end
      3: begin
        if (angle_field) v = 32'($urandom_range(94371840)) - 32'd47185920;  // +/-720 deg
        else             v = 32'($urandom_range(2097152)) - 32'd1048576;
      end
      4: begin
        case ($urandom_range(6))
          0:       v = 32'h0000_0000;
          1:       v = 32'h0000_0001;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'h7FFF_FFFF;
          4:       v = 32'h8000_0000;
          5:       v = 32'h0001_0000;
          default: v = 32'hFFFF_0000;
        endcase
      end
      default: begin
        // multiples of 45 deg in -360..360, or an axis for components
        if (angle_field) v = 32'($urandom_range(16)) * 32'd2949120 - 32'd23592960;
        else             v = 32'h0000_0000;
      end
    endcase
    return v;
  endfunction

  task automatic random_conversions(input int count, input int pause_at);
    req_type_t kind;
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) drain_results();
      kind = req_type_t'($urandom_range(1));
      issue_conversion(kind, random_coord(1'b0), random_coord(kind == REQ_POLAR_TO_RECT));
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_RECT_TO_POLAR;
    req_ch.first_coord  <= '0;
    req_ch.second_coord <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // rectangular to polar corners
    issue_conversion(REQ_RECT_TO_POLAR, 32'h0000_0000, 32'h0000_0000);  // zero vector
    issue_conversion(REQ_RECT_TO_POLAR, 32'h0000_0001, 32'h0000_0000);
    issue_conversion(REQ_RECT_TO_POLAR, 32'h0003_0000, 32'h0004_0000);
    issue_conversion(REQ_RECT_TO_POLAR, 32'h0000_0000, 32'h0001_0000);
    issue_conversion(REQ_RECT_TO_POLAR, 32'h0000_0000, 32'hFFFF_0000);
    issue_conversion(REQ_RECT_TO_POLAR, 32'hFFFF_0000, 32'h0000_0000);  // lands on +180
    issue_conversion(REQ_RECT_TO_POLAR, 32'hFFFF_0000, 32'hFFFF_FFFF);  // just under -180
    issue_conversion(REQ_RECT_TO_POLAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF);  // magnitude clips
    issue_conversion(REQ_RECT_TO_POLAR, 32'h8000_0000, 32'h8000_0000);
    issue_conversion(REQ_RECT_TO_POLAR, 32'h8000_0000, 32'h0000_0000);
    issue_conversion(REQ_RECT_TO_POLAR, 32'h7FFF_FFFF, 32'h8000_0000);
    // polar to rectangular: wrap, fold, sign and overflow corners
    issue_conversion(REQ_POLAR_TO_RECT, 32'h0001_0000, 32'h0000_0000);
    issue_conversion(REQ_POLAR_TO_RECT, 32'h0001_0000, 32'h005A_0000);  // +90, no fold
    issue_conversion(REQ_POLAR_TO_RECT, 32'h0001_0000, 32'hFFA6_0000);  // -90
    issue_conversion(REQ_POLAR_TO_RECT, 32'h0001_0000, 32'h00B4_0000);  // +180
    issue_conversion(REQ_POLAR_TO_RECT, 32'h0001_0000, 32'hFF4C_0000);  // -180 wraps
    issue_conversion(REQ_POLAR_TO_RECT, 32'h0001_0000, 32'h010E_0000);  // 270
    issue_conversion(REQ_POLAR_TO_RECT, 32'h0001_0000, 32'h7FFF_FFFF);
    issue_conversion(REQ_POLAR_TO_RECT, 32'h0001_0000, 32'h8000_0000);
    issue_conversion(REQ_POLAR_TO_RECT, 32'hFFFB_0000, 32'h001E_0000);  // negative magnitude
    issue_conversion(REQ_POLAR_TO_RECT, 32'h7FFF_FFFF, 32'h0000_0000);
    issue_conversion(REQ_POLAR_TO_RECT, 32'h7FFF_FFFF, 32'h002D_0000);
    issue_conversion(REQ_POLAR_TO_RECT, 32'h8000_0000, 32'h00B4_0000);  // component clips
    issue_conversion(REQ_POLAR_TO_RECT, 32'h8000_0000, 32'h0000_0000);
    issue_conversion(REQ_POLAR_TO_RECT, 32'h0000_0000, 32'h1234_5678);

    random_conversions(PHASE_ITEMS, PHASE_ITEMS / 2);
    drain_results();

    send_idle_pct = 65;
    recv_idle_pct = 22;
    random_conversions(PHASE_ITEMS, -1);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_conversions(PHASE_ITEMS, -1);
    drain_results();

    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
